/* rtl/core/sac_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the stick axis conditioner.
// Standalone package; used by rtl/core/stick_axis_conditioner.sv.

package sac_pkg;

   // Q1.15 full scale and its square
   localparam logic [14:0] FULL_SCALE = 15'd32767;
   localparam logic [30:0] FULL_SQ    = 31'd1073676289;

   // Reset value of the press threshold (0.8 in Q1.15)
   localparam logic [14:0] THRESH_RESET = 15'd26214;

   // Bit positions in the held and pressed masks
   localparam int unsigned BIT_UP    = 0;
   localparam int unsigned BIT_DOWN  = 1;
   localparam int unsigned BIT_LEFT  = 2;
   localparam int unsigned BIT_RIGHT = 3;

   // Step counts of the serial units
   localparam logic [4:0] SQ_STEPS   = 5'd15;
   localparam logic [4:0] ROOT_STEPS = 5'd16;
   localparam logic [4:0] DIV_STEPS  = 5'd15;

   // Request kinds carried on the input tuser
   typedef enum logic [2:0] {
      REQ_AXIS_X = 3'd0,
      REQ_AXIS_Y = 3'd1,
      REQ_UP     = 3'd2,
      REQ_DOWN   = 3'd3,
      REQ_LEFT   = 3'd4,
      REQ_RIGHT  = 3'd5,
      REQ_CLEAR  = 3'd6
   } req_code_type;

   // Configuration register indexes
   typedef enum logic {
      CSR_DEAD_ZONE = 1'b0,
      CSR_THRESHOLD = 1'b1
   } csr_index_type;

   // Sequencer states, one-hot
   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_SQR  = 8'b0000_0010,
      ST_SUM  = 8'b0000_0100,
      ST_CMP  = 8'b0000_1000,
      ST_ROOT = 8'b0001_0000,
      ST_DSET = 8'b0010_0000,
      ST_DIV  = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   // One step of a serial shift-add square: product {hi, lo} with lo
   // preloaded with the operand
   function automatic logic [29:0] sq_step(input logic [29:0] p, input logic [14:0] a);
      logic [15:0] sum;
      sum = {1'b0, p[29:15]} + (p[0] ? {1'b0, a} : 16'd0);
      return {sum, p[14:1]};
   endfunction

endpackage

/* rtl/core/stick_axis_conditioner.sv */
`timescale 1ns / 1ps
// Stick axis conditioner: position state, press edges, radial dead zone and
// normalization with bit-serial square, square root and divide. Uses sac_pkg.
//
// Each word passes through the states square (15 steps), sum, compare and
// done; when the vector is longer than 1.0 it also passes through root
// (16 steps), divide setup and divide (15 steps) before done.
// The next word is taken as soon as the result register loads, which waits
// while an earlier result there is not yet taken. The serial square, root
// and divide units are the pacing elements and work on one word at a time.
// Reset: synchronous, active high; clears position, held and pressed bits,
// dead zone to zero, press threshold to 0.8.

module stick_axis_conditioner (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] sample, [16] button_down, [23:17] zero
   input  logic [2:0]  req_tuser,   // [2:0] req_type
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] axis_x, [31:16] axis_y, [32] up_pressed,
                                    // [33] down_pressed, [34] left_pressed,
                                    // [35] right_pressed, [39:36] zero
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [14:0] csr_data
);

   sac_pkg::state_type state_ff, state_in;
   logic [4:0]         cnt_ff, cnt_in;

   logic [14:0]        dz_ff, dz_in;
   logic [14:0]        th_ff, th_in;

   logic signed [15:0] x_ff, x_in;
   logic signed [15:0] y_ff, y_in;
   logic [3:0]         held_ff, held_in;
   logic [3:0]         flags_ff, flags_in;

   logic [29:0]        sqx_ff, sqx_in;
   logic [29:0]        sqy_ff, sqy_in;
   logic [29:0]        sqd_ff, sqd_in;
   logic [30:0]        len_ff, len_in;

   logic [16:0]        srem_ff, srem_in;
   logic [15:0]        sroot_ff, sroot_in;
   logic [31:0]        sn_ff, sn_in;

   logic [15:0]        dremx_ff, dremx_in, dremy_ff, dremy_in;
   logic [14:0]        dnumx_ff, dnumx_in, dnumy_ff, dnumy_in;
   logic [14:0]        dqx_ff, dqx_in, dqy_ff, dqy_in;

   logic signed [15:0] resx_ff, resx_in;
   logic signed [15:0] resy_ff, resy_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [39:0]        rsp_data_ff, rsp_data_in;

   // request decode and state update terms
   logic               req_fire;
   logic               btn_down;
   logic signed [15:0] smp_clamp;
   logic signed [16:0] vx, vy, th_pos, th_neg, ax17, ay17;
   logic signed [15:0] upd_x, upd_y;
   logic [3:0]         upd_held, upd_flags;
   logic [14:0]        mag_x, mag_y, mag_ux, mag_uy;

   // serial unit terms
   logic [18:0]        root_trial;
   logic [19:0]        root_diff;
   logic [16:0]        divx_trial, divy_trial;
   logic [17:0]        divx_diff, divy_diff;
   logic [29:0]        numx, numy;
   logic               out_free;

   assign req_fire   = req_tvalid & req_tready;
   assign req_tready = (state_ff == sac_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // Clamp the sample to +-full scale
   assign btn_down  = req_tdata[16];
   assign smp_clamp = (req_tdata[15:0] == 16'h8000) ? -16'sd32767 : $signed(req_tdata[15:0]);
   assign vx        = {smp_clamp[15], smp_clamp};
   assign vy        = -vx;
   assign th_pos    = $signed({2'b00, th_ff});
   assign th_neg    = -th_pos;
   assign ax17      = {x_ff[15], x_ff};
   assign ay17      = {y_ff[15], y_ff};

   // Apply one request to the position, held and pressed state
   always_comb begin
      upd_x     = x_ff;
      upd_y     = y_ff;
      upd_held  = held_ff;
      upd_flags = flags_ff;
      case (sac_pkg::req_code_type'(req_tuser))
         sac_pkg::REQ_AXIS_X: begin
            if (held_ff == 4'd0) begin
               if (vx >= th_pos && ax17 < th_pos) upd_flags[sac_pkg::BIT_RIGHT] = 1'b1;
               if (vx <= th_neg && ax17 > th_neg) upd_flags[sac_pkg::BIT_LEFT] = 1'b1;
               upd_x = vx[15:0];
            end
         end
         sac_pkg::REQ_AXIS_Y: begin
            if (held_ff == 4'd0) begin
               if (vy >= th_pos && ay17 < th_pos) upd_flags[sac_pkg::BIT_UP] = 1'b1;
               if (vy <= th_neg && ay17 > th_neg) upd_flags[sac_pkg::BIT_DOWN] = 1'b1;
               upd_y = vy[15:0];
            end
         end
         sac_pkg::REQ_UP: begin
            if (btn_down) begin
               if (!held_ff[sac_pkg::BIT_UP]) begin
                  upd_held[sac_pkg::BIT_UP]  = 1'b1;
                  upd_flags[sac_pkg::BIT_UP] = 1'b1;
               end
               upd_y = 16'sd32767;
            end else begin
               upd_held[sac_pkg::BIT_UP] = 1'b0;
               if (y_ff == 16'sd32767) upd_y = 16'sd0;
            end
         end
         sac_pkg::REQ_DOWN: begin
            if (btn_down) begin
               if (!held_ff[sac_pkg::BIT_DOWN]) begin
                  upd_held[sac_pkg::BIT_DOWN]  = 1'b1;
                  upd_flags[sac_pkg::BIT_DOWN] = 1'b1;
               end
               upd_y = -16'sd32767;
            end else begin
               upd_held[sac_pkg::BIT_DOWN] = 1'b0;
               if (y_ff == -16'sd32767) upd_y = 16'sd0;
            end
         end
         sac_pkg::REQ_LEFT: begin
            if (btn_down) begin
               if (!held_ff[sac_pkg::BIT_LEFT]) begin
                  upd_held[sac_pkg::BIT_LEFT]  = 1'b1;
                  upd_flags[sac_pkg::BIT_LEFT] = 1'b1;
               end
               upd_x = -16'sd32767;
            end else begin
               upd_held[sac_pkg::BIT_LEFT] = 1'b0;
               if (x_ff == -16'sd32767) upd_x = 16'sd0;
            end
         end
         sac_pkg::REQ_RIGHT: begin
            if (btn_down) begin
               if (!held_ff[sac_pkg::BIT_RIGHT]) begin
                  upd_held[sac_pkg::BIT_RIGHT]  = 1'b1;
                  upd_flags[sac_pkg::BIT_RIGHT] = 1'b1;
               end
               upd_x = 16'sd32767;
            end else begin
               upd_held[sac_pkg::BIT_RIGHT] = 1'b0;
               if (x_ff == 16'sd32767) upd_x = 16'sd0;
            end
         end
         sac_pkg::REQ_CLEAR: upd_flags = 4'd0;
         default: ;
      endcase
   end

   // Magnitudes of the stored and the updated position
   assign mag_x  = x_ff[15] ? 15'(-x_ff) : x_ff[14:0];
   assign mag_y  = y_ff[15] ? 15'(-y_ff) : y_ff[14:0];
   assign mag_ux = upd_x[15] ? 15'(-upd_x) : upd_x[14:0];
   assign mag_uy = upd_y[15] ? 15'(-upd_y) : upd_y[14:0];

   // Root step: bring in two bits, try subtracting 4*root+1
   assign root_trial = {srem_ff, sn_ff[31:30]};
   assign root_diff  = {1'b0, root_trial} - {2'b00, sroot_ff, 2'b01};

   // Divide step per lane: bring in one numerator bit, try subtracting root
   assign divx_trial = {dremx_ff, dnumx_ff[14]};
   assign divy_trial = {dremy_ff, dnumy_ff[14]};
   assign divx_diff  = {1'b0, divx_trial} - {2'b00, sroot_ff};
   assign divy_diff  = {1'b0, divy_trial} - {2'b00, sroot_ff};

   // Numerators |c| * 32767 as a shift and subtract
   assign numx = {mag_x, 15'd0} - {15'd0, mag_x};
   assign numy = {mag_y, 15'd0} - {15'd0, mag_y};

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      dz_in        = dz_ff;
      th_in        = th_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      held_in      = held_ff;
      flags_in     = flags_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      sqd_in       = sqd_ff;
      len_in       = len_ff;
      srem_in      = srem_ff;
      sroot_in     = sroot_ff;
      sn_in        = sn_ff;
      dremx_in     = dremx_ff;
      dremy_in     = dremy_ff;
      dnumx_in     = dnumx_ff;
      dnumy_in     = dnumy_ff;
      dqx_in       = dqx_ff;
      dqy_in       = dqy_ff;
      resx_in      = resx_ff;
      resy_in      = resy_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      // take configuration writes
      if (csr_valid && csr_ready) begin
         unique case (sac_pkg::csr_index_type'(csr_index))
            sac_pkg::CSR_DEAD_ZONE: dz_in = csr_data;
            sac_pkg::CSR_THRESHOLD: th_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         sac_pkg::ST_IDLE: begin
            // accept a word, update state, preload the squarers
            if (req_fire) begin
               x_in     = upd_x;
               y_in     = upd_y;
               held_in  = upd_held;
               flags_in = upd_flags;
               sqx_in   = {15'd0, mag_ux};
               sqy_in   = {15'd0, mag_uy};
               sqd_in   = {15'd0, dz_ff};
               cnt_in   = 5'd0;
               state_in = sac_pkg::ST_SQR;
            end
         end
         sac_pkg::ST_SQR: begin
            // one multiplier bit per cycle for x^2, y^2 and dead_zone^2
            sqx_in = sac_pkg::sq_step(sqx_ff, mag_x);
            sqy_in = sac_pkg::sq_step(sqy_ff, mag_y);
            sqd_in = sac_pkg::sq_step(sqd_ff, dz_ff);
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == sac_pkg::SQ_STEPS - 5'd1) state_in = sac_pkg::ST_SUM;
         end
         sac_pkg::ST_SUM: begin
            len_in   = {1'b0, sqx_ff} + {1'b0, sqy_ff};
            state_in = sac_pkg::ST_CMP;
         end
         sac_pkg::ST_CMP: begin
            // dead zone, pass through, or normalize
            if (len_ff < {1'b0, sqd_ff}) begin
               resx_in  = 16'sd0;
               resy_in  = 16'sd0;
               state_in = sac_pkg::ST_DONE;
            end else if (len_ff > sac_pkg::FULL_SQ) begin
               sn_in    = {1'b0, len_ff};
               srem_in  = 17'd0;
               sroot_in = 16'd0;
               cnt_in   = 5'd0;
               state_in = sac_pkg::ST_ROOT;
            end else begin
               resx_in  = x_ff;
               resy_in  = y_ff;
               state_in = sac_pkg::ST_DONE;
            end
         end
         sac_pkg::ST_ROOT: begin
            // one root bit per cycle
            sn_in = {sn_ff[29:0], 2'b00};
            if (!root_diff[19]) begin
               srem_in  = root_diff[16:0];
               sroot_in = {sroot_ff[14:0], 1'b1};
            end else begin
               srem_in  = root_trial[16:0];
               sroot_in = {sroot_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == sac_pkg::ROOT_STEPS - 5'd1) state_in = sac_pkg::ST_DSET;
         end
         sac_pkg::ST_DSET: begin
            // load numerators; the top half is already below the root
            dremx_in = {1'b0, numx[29:15]};
            dremy_in = {1'b0, numy[29:15]};
            dnumx_in = numx[14:0];
            dnumy_in = numy[14:0];
            dqx_in   = 15'd0;
            dqy_in   = 15'd0;
            cnt_in   = 5'd0;
            state_in = sac_pkg::ST_DIV;
         end
         sac_pkg::ST_DIV: begin
            // one quotient bit per cycle in each lane
            dnumx_in = {dnumx_ff[13:0], 1'b0};
            dnumy_in = {dnumy_ff[13:0], 1'b0};
            if (!divx_diff[17]) begin
               dremx_in = divx_diff[15:0];
               dqx_in   = {dqx_ff[13:0], 1'b1};
            end else begin
               dremx_in = divx_trial[15:0];
               dqx_in   = {dqx_ff[13:0], 1'b0};
            end
            if (!divy_diff[17]) begin
               dremy_in = divy_diff[15:0];
               dqy_in   = {dqy_ff[13:0], 1'b1};
            end else begin
               dremy_in = divy_trial[15:0];
               dqy_in   = {dqy_ff[13:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == sac_pkg::DIV_STEPS - 5'd1) begin
               resx_in  = x_ff[15] ? -$signed({1'b0, dqx_in}) : $signed({1'b0, dqx_in});
               resy_in  = y_ff[15] ? -$signed({1'b0, dqy_in}) : $signed({1'b0, dqy_in});
               state_in = sac_pkg::ST_DONE;
            end
         end
         sac_pkg::ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_data_in  = {4'd0, flags_ff, resy_ff, resx_ff};
               rsp_valid_in = 1'b1;
               state_in     = sac_pkg::ST_IDLE;
            end
         end
         default: state_in = sac_pkg::ST_IDLE;
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sac_pkg::ST_IDLE;
         cnt_ff       <= 5'd0;
         dz_ff        <= 15'd0;
         th_ff        <= sac_pkg::THRESH_RESET;
         x_ff         <= 16'sd0;
         y_ff         <= 16'sd0;
         held_ff      <= 4'd0;
         flags_ff     <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dz_ff        <= dz_in;
         th_ff        <= th_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         held_ff      <= held_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      sqd_ff      <= sqd_in;
      len_ff      <= len_in;
      srem_ff     <= srem_in;
      sroot_ff    <= sroot_in;
      sn_ff       <= sn_in;
      dremx_ff    <= dremx_in;
      dremy_ff    <= dremy_in;
      dnumx_ff    <= dnumx_in;
      dnumy_ff    <= dnumy_in;
      dqx_ff      <= dqx_in;
      dqy_ff      <= dqy_in;
      resx_ff     <= resx_in;
      resy_ff     <= resy_in;
      rsp_data_ff <= rsp_data_in;
   end

   // An accepted word always starts the squarers
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == sac_pkg::ST_SQR)
      else $error("accepted word did not start the square unit");

   // Normalization only runs with a root of at least full scale
   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      state_ff == sac_pkg::ST_DIV |-> sroot_ff >= 16'd32767)
      else $error("divide started with a root below full scale");

   // Results never reach the most negative code
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[15:0] != 16'h8000) && (rsp_data_ff[31:16] != 16'h8000))
      else $error("result component out of range");

   // Root step counter stays within the root unit's length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == sac_pkg::ST_ROOT |-> cnt_ff < sac_pkg::ROOT_STEPS)
      else $error("root step counter overran");

endmodule
